/* rtl/rxah64_pkg.sv */
// Package for the rotate-xor-add 64-bit hash block.
// Holds request codes, state reset constants, command/status structs and the mix function.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rxah64_pkg;

    // Request codes carried by req_type.
    localparam logic [1:0] REQ_ABSORB        = 2'd0;
    localparam logic [1:0] REQ_ABSORB_FINISH = 2'd1;
    localparam logic [1:0] REQ_FINISH        = 2'd2;

    // Initial values of the mixing state and the padding marker.
    localparam logic [31:0] INIT_A   = 32'h243F6A88;
    localparam logic [31:0] INIT_B   = 32'h85A308D3;
    localparam logic [7:0]  PAD_MARK = 8'h80;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic absorb;    // take data_byte into the current block
        logic mix_pad;   // mix the partial word with the pad marker
        logic mix_zero;  // mix an all-zero word
        logic finish;    // capture the hash and return the state to reset
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic       pos_lt16;  // block position is in the mixed half
        logic       pos_gt27;  // block position leaves no room for the length
        logic [1:0] word_idx;  // index of the word holding the position
    } status_t;

    // One rotate-xor-add step; returns {a_new, b_new}.
    function automatic logic [63:0] mix_word(input logic [31:0] a,
                                             input logic [31:0] b,
                                             input logic [31:0] w);
        logic [31:0] ax;
        logic [31:0] bw;
        logic [31:0] a_new;
        logic [31:0] b_new;
        ax    = a ^ w;
        bw    = b + w;
        a_new = {ax[26:0], ax[31:27]} + b;
        b_new = {bw[20:0], bw[31:21]} ^ a_new;
        return {a_new, b_new};
    endfunction

endpackage

`default_nettype wire

/* rtl/rotate_xor_add_hash64_top.sv */
// Top level of the rotate-xor-add 64-bit hash block.
// A byte is accepted every cycle while the controller is idle; in_stall is held during a finish.
// A finish runs one padding step, up to four zero-word mixes in the single shared mix unit,
// and one result capture, which waits while the output is stalled.
// Reset returns the hash state to its initial values and clears the output.
// Depends on rxah64_pkg, rxah64_ctrl and rxah64_dp.
`timescale 1ns / 1ps
`default_nettype none

module rotate_xor_add_hash64_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  req_type,
    input  wire logic [7:0]  data_byte,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [63:0]      hash_value
);

    rxah64_pkg::cmd_t    cmd;
    rxah64_pkg::status_t status;

    // Controller.
    rxah64_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .req_type  (req_type),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    // Datapath.
    rxah64_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .data_byte  (data_byte),
        .status     (status),
        .hash_value (hash_value)
    );

endmodule

`default_nettype wire

/* rtl/rxah64_dp.sv */
// Datapath of the rotate-xor-add 64-bit hash block.
// Holds the mixing state, block position, partial word and the result register.
// Depends on rxah64_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rxah64_dp (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire rxah64_pkg::cmd_t  cmd,
    input  wire logic [7:0]        data_byte,
    output rxah64_pkg::status_t    status,
    output logic [63:0]            hash_value
);

    logic [31:0] a_reg;
    logic [31:0] a_next;
    logic [31:0] b_reg;
    logic [31:0] b_next;
    logic [4:0]  pos_reg;
    logic [4:0]  pos_next;
    logic [23:0] partial_reg;
    logic [23:0] partial_next;
    logic [63:0] hash_reg;
    logic [63:0] hash_next;

    logic [1:0]  lane;
    logic [31:0] mix_in;
    logic        do_mix;
    logic [63:0] mix_out;
    logic [31:0] pad_word;

    assign lane = pos_reg[1:0];

    // Status toward the controller.
    assign status.pos_lt16 = (pos_reg[4] == 1'b0);
    assign status.pos_gt27 = (pos_reg > 5'd27);
    assign status.word_idx = pos_reg[3:2];

    // Partial word closed with the pad marker at the current lane.
    assign pad_word = {8'h00, partial_reg} | ({24'h000000, rxah64_pkg::PAD_MARK} << {lane, 3'b000});

    // Select the word to mix and whether a mix happens this cycle.
    always_comb
    begin
        mix_in = 32'h0;
        do_mix = 1'b0;
        if (cmd.absorb && status.pos_lt16 && (lane == 2'd3))
        begin
            mix_in = {data_byte, partial_reg};
            do_mix = 1'b1;
        end
        else if (cmd.mix_pad)
        begin
            mix_in = pad_word;
            do_mix = 1'b1;
        end
        else if (cmd.mix_zero)
        begin
            do_mix = 1'b1;
        end
    end

    assign mix_out = rxah64_pkg::mix_word(a_reg, b_reg, mix_in);

    // Next-state logic for the hash state.
    always_comb
    begin
        a_next       = a_reg;
        b_next       = b_reg;
        pos_next     = pos_reg;
        partial_next = partial_reg;
        hash_next    = hash_reg;
        if (do_mix)
        begin
            a_next = mix_out[63:32];
            b_next = mix_out[31:0];
        end
        if (cmd.absorb)
        begin
            pos_next = pos_reg + 5'd1;
            if (status.pos_lt16)
            begin
                if (lane == 2'd3)
                begin
                    partial_next = 24'h0;
                end
                else
                begin
                    partial_next = partial_reg | ({16'h0000, data_byte} << {lane, 3'b000});
                end
            end
        end
        if (cmd.finish)
        begin
            hash_next    = {a_reg ^ {b_reg[28:0], b_reg[31:29]}, b_reg};
            a_next       = rxah64_pkg::INIT_A;
            b_next       = rxah64_pkg::INIT_B;
            pos_next     = 5'd0;
            partial_next = 24'h0;
        end
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_reg       <= rxah64_pkg::INIT_A;
            b_reg       <= rxah64_pkg::INIT_B;
            pos_reg     <= 5'd0;
            partial_reg <= 24'h0;
        end
        else
        begin
            a_reg       <= a_next;
            b_reg       <= b_next;
            pos_reg     <= pos_next;
            partial_reg <= partial_next;
        end
    end

    // Result register; qualified by the controller's valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_reg <= 64'h0;
        end
        else
        begin
            hash_reg <= hash_next;
        end
    end

    assign hash_value = hash_reg;

endmodule

`default_nettype wire

/* rtl/rxah64_ctrl.sv */
// Controller of the rotate-xor-add 64-bit hash block.
// Runs the input handshake, the finishing sequence and the output valid flag.
// Depends on rxah64_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rxah64_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic [1:0]           req_type,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    input  wire rxah64_pkg::status_t  status,
    output rxah64_pkg::cmd_t          cmd
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_PAD  = 4'b0010,
        S_ZERO = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

    state_t      state_reg;
    state_t      state_next;
    logic [2:0]  zcnt_reg;
    logic [2:0]  zcnt_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        in_take;
    logic        out_free;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_take   = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    // Sequencing of absorb and finish transactions.
    always_comb
    begin
        state_next     = state_reg;
        zcnt_next      = zcnt_reg;
        cmd            = '0;
        out_valid_next = out_valid_reg && out_stall;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_take)
                begin
                    case (req_type)
                        rxah64_pkg::REQ_ABSORB:
                        begin
                            cmd.absorb = 1'b1;
                        end
                        rxah64_pkg::REQ_ABSORB_FINISH:
                        begin
                            cmd.absorb = 1'b1;
                            state_next = S_PAD;
                        end
                        rxah64_pkg::REQ_FINISH:
                        begin
                            state_next = S_PAD;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_PAD:
            begin
                if (status.pos_lt16)
                begin
                    cmd.mix_pad = 1'b1;
                    zcnt_next   = {1'b0, 2'd3 - status.word_idx};
                    state_next  = (status.word_idx == 2'd3) ? S_DONE : S_ZERO;
                end
                else if (status.pos_gt27)
                begin
                    zcnt_next  = 3'd4;
                    state_next = S_ZERO;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_ZERO:
            begin
                cmd.mix_zero = 1'b1;
                zcnt_next    = zcnt_reg - 3'd1;
                if (zcnt_reg == 3'd1)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    cmd.finish     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            zcnt_reg      <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            zcnt_reg      <= zcnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire
